### rtl/key_value_lexer_unit_assert.svh
// Assertion macros shared by the lexer RTL files.
`ifndef KEY_VALUE_LEXER_UNIT_ASSERT_SVH
`define KEY_VALUE_LEXER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define KVL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define KVL_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KVL_ASSERT(lbl, clk, rst_n, prop, msg)
`define KVL_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/kvl_pkg.sv
// Types, constants and helpers shared by the key/value lexer modules.
package kvl_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int FIELD_W = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_W = 8;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

	localparam logic [CFG_W-1:0] ASSIGN_RST = 8'd61;
	localparam logic [CFG_W-1:0] DELIM_RST = 8'd59;
	localparam logic [CFG_W-1:0] COMMENT_RST = 8'd35;

	typedef enum logic [1:0] {
		REG_ASSIGN = 2'd0,
		REG_DELIM = 2'd1,
		REG_COMMENT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_ASSIGN = 3'd0,
		KIND_DELIM = 3'd1,
		KIND_IDENT = 3'd2,
		KIND_UNKNOWN = 3'd3,
		KIND_END = 3'd4
	} token_kind_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_IDENT = 2'd2
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic is_end;
	} kvl_in_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [FIELD_W-1:0] token_line;
		logic [FIELD_W-1:0] token_column;
		logic [FIELD_W-1:0] start_offset;
		logic [FIELD_W-1:0] token_length;
		logic last;
	} kvl_out_t;

	typedef struct packed {
		token_kind_t kind;
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] column;
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] length;
	} kvl_tok_t;

	// One queued request: tok_b is always present, tok_a only when two is set.
	typedef struct packed {
		logic two;
		kvl_tok_t tok_a;
		kvl_tok_t tok_b;
	} kvl_entry_t;

	typedef struct packed {
		logic we;
		cfg_reg_t index;
		logic [CFG_W-1:0] data;
	} kvl_cfg_wr_t;

	function automatic logic [FIELD_W-1:0] to_field(logic [31:0] v);
		return v[FIELD_W-1:0];
	endfunction

endpackage

### rtl/kvl_queue.sv
// Short token queue between the lexer front end and the output stage.
`include "key_value_lexer_unit_assert.svh"

module kvl_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input kvl_pkg::kvl_entry_t push_data,
	output logic full,
	input logic pop,
	output kvl_pkg::kvl_entry_t pop_data,
	output logic empty
);

	localparam int DEPTH = kvl_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	kvl_pkg::kvl_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`KVL_NEVER(a_queue_no_overflow, clk, arst_n, push && full, "push into a full token queue")
	`KVL_NEVER(a_queue_no_underflow, clk, arst_n, pop && empty, "pop from an empty token queue")

endmodule

### rtl/kvl_front.sv
// Lexer front end: classifies bytes, tracks position and mode, queues tokens.
`include "key_value_lexer_unit_assert.svh"

module kvl_front #(
	parameter int COUNT_BITS = kvl_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input kvl_pkg::kvl_cfg_wr_t cfg,
	input logic in_valid,
	output logic in_stall,
	input kvl_pkg::kvl_in_t in_data,
	output logic push,
	output kvl_pkg::kvl_entry_t push_data,
	input logic full
);

	logic [kvl_pkg::CFG_W-1:0] assign_char_q;
	logic [kvl_pkg::CFG_W-1:0] delim_char_q;
	logic [kvl_pkg::CFG_W-1:0] comment_char_q;

	kvl_pkg::lex_mode_t mode_q;
	kvl_pkg::lex_mode_t mode_d;
	kvl_pkg::lex_mode_t nb_mode;
	logic [COUNT_BITS-1:0] line_q;
	logic [COUNT_BITS-1:0] col_q;
	logic [COUNT_BITS-1:0] off_q;
	logic [COUNT_BITS-1:0] id_line_q;
	logic [COUNT_BITS-1:0] id_col_q;
	logic [COUNT_BITS-1:0] id_off_q;
	logic [COUNT_BITS-1:0] line_n;
	logic [COUNT_BITS-1:0] col_n;
	logic [COUNT_BITS-1:0] off_n;
	logic [COUNT_BITS-1:0] id_len;

	logic accept;
	logic end_i;
	logic [7:0] b;
	logic nl;
	logic is_ws;
	logic is_letter;
	logic is_digit;
	logic ident_c;
	logic cls_ws;
	logic cls_asg;
	logic cls_del;
	logic cls_com;
	logic cls_id;
	logic cls_unk;
	logic flush;
	logic run_nb;
	logic sec_v;
	logic capture;
	kvl_pkg::kvl_tok_t flush_tok;
	kvl_pkg::kvl_tok_t sec_tok;

	assign in_stall = full;
	assign accept = in_valid && !full;
	assign end_i = in_data.is_end;
	assign b = in_data.in_byte;

	// Byte classes, checked in priority order: whitespace, assign, delimiter, comment, letter or underscore.
	assign nl = (b == kvl_pkg::CHAR_NEWLINE);
	assign is_ws = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	assign is_letter = ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
	assign is_digit = (b >= 8'd48) && (b <= 8'd57);
	assign ident_c = is_letter || is_digit || (b == kvl_pkg::CHAR_UNDERSCORE);
	assign cls_ws = is_ws;
	assign cls_asg = !cls_ws && (b == assign_char_q);
	assign cls_del = !cls_ws && !cls_asg && (b == delim_char_q);
	assign cls_com = !cls_ws && !cls_asg && !cls_del && (b == comment_char_q);
	assign cls_id = !cls_ws && !cls_asg && !cls_del && !cls_com
		&& (is_letter || (b == kvl_pkg::CHAR_UNDERSCORE));
	assign cls_unk = !cls_ws && !cls_asg && !cls_del && !cls_com && !cls_id;

	assign nb_mode = cls_com ? kvl_pkg::MODE_COMMENT
		: (cls_id ? kvl_pkg::MODE_IDENT : kvl_pkg::MODE_NORMAL);

	// Position after this byte is consumed; all counters saturate.
	assign off_n = (&off_q) ? off_q : off_q + 1'b1;
	assign line_n = nl ? ((&line_q) ? line_q : line_q + 1'b1) : line_q;
	assign col_n = nl ? COUNT_BITS'(1) : ((&col_q) ? col_q : col_q + 1'b1);
	assign id_len = (off_q >= id_off_q) ? off_q - id_off_q : '0;

	always_comb begin
		mode_d = mode_q;
		if (end_i) begin
			mode_d = kvl_pkg::MODE_NORMAL;
		end else begin
			case (mode_q)
				kvl_pkg::MODE_COMMENT: begin
					if (nl) begin
						mode_d = kvl_pkg::MODE_NORMAL;
					end
				end
				kvl_pkg::MODE_IDENT: begin
					if (!ident_c) begin
						mode_d = nb_mode;
					end
				end
				default: begin
					mode_d = nb_mode;
				end
			endcase
		end
	end

	always_comb begin
		flush = 1'b0;
		run_nb = 1'b0;
		if (end_i) begin
			flush = (mode_q == kvl_pkg::MODE_IDENT);
		end else begin
			case (mode_q)
				kvl_pkg::MODE_COMMENT: begin
					run_nb = 1'b0;
				end
				kvl_pkg::MODE_IDENT: begin
					flush = !ident_c;
					run_nb = !ident_c;
				end
				default: begin
					run_nb = 1'b1;
				end
			endcase
		end
	end

	assign sec_v = end_i || (run_nb && (cls_asg || cls_del || cls_unk));
	assign capture = run_nb && cls_id;

	always_comb begin
		flush_tok.kind = kvl_pkg::KIND_IDENT;
		flush_tok.line = kvl_pkg::to_field(32'(id_line_q));
		flush_tok.column = kvl_pkg::to_field(32'(id_col_q));
		flush_tok.offset = kvl_pkg::to_field(32'(id_off_q));
		flush_tok.length = kvl_pkg::to_field(32'(id_len));

		// Single-byte tokens report the position after their own byte.
		if (end_i) begin
			sec_tok.kind = kvl_pkg::KIND_END;
			sec_tok.line = kvl_pkg::to_field(32'(line_q));
			sec_tok.column = kvl_pkg::to_field(32'(col_q));
		end else begin
			sec_tok.kind = cls_asg ? kvl_pkg::KIND_ASSIGN
				: (cls_del ? kvl_pkg::KIND_DELIM : kvl_pkg::KIND_UNKNOWN);
			sec_tok.line = kvl_pkg::to_field(32'(line_n));
			sec_tok.column = kvl_pkg::to_field(32'(col_n));
		end
		sec_tok.offset = '0;
		sec_tok.length = '0;

		push_data.two = flush && sec_v;
		push_data.tok_a = flush_tok;
		push_data.tok_b = (flush && !sec_v) ? flush_tok : sec_tok;
	end

	assign push = accept && (flush || sec_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assign_char_q <= kvl_pkg::ASSIGN_RST;
			delim_char_q <= kvl_pkg::DELIM_RST;
			comment_char_q <= kvl_pkg::COMMENT_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				kvl_pkg::REG_ASSIGN: assign_char_q <= cfg.data;
				kvl_pkg::REG_DELIM: delim_char_q <= cfg.data;
				kvl_pkg::REG_COMMENT: comment_char_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kvl_pkg::MODE_NORMAL;
			line_q <= COUNT_BITS'(1);
			col_q <= COUNT_BITS'(1);
			off_q <= '0;
			id_line_q <= '0;
			id_col_q <= '0;
			id_off_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (!end_i) begin
				line_q <= line_n;
				col_q <= col_n;
				off_q <= off_n;
			end
			if (capture) begin
				id_line_q <= line_q;
				id_col_q <= col_q;
				id_off_q <= off_q;
			end
		end
	end

	`KVL_ASSERT(a_front_pos_nonzero, clk, arst_n, (line_q != '0) && (col_q != '0), "line or column reached zero")
	`KVL_ASSERT(a_front_ident_order, clk, arst_n, (mode_q == kvl_pkg::MODE_IDENT) |-> (id_off_q <= off_q), "identifier start lies past the current offset")

endmodule

### rtl/kvl_back.sv
// Lexer back end: output register that delivers one or two tokens per queued request.
`include "key_value_lexer_unit_assert.svh"

module kvl_back (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input kvl_pkg::kvl_entry_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output kvl_pkg::kvl_out_t out_data
);

	kvl_pkg::kvl_entry_t stage_q;
	logic stage_v_q;
	logic sel_q;
	logic first_of_two;
	logic take;
	logic done;
	kvl_pkg::kvl_tok_t cur;

	assign first_of_two = !sel_q && stage_q.two;
	assign take = stage_v_q && !out_stall;
	assign done = take && !first_of_two;
	assign pop = (!stage_v_q || done) && !empty;

	assign cur = first_of_two ? stage_q.tok_a : stage_q.tok_b;
	assign out_valid = stage_v_q;

	always_comb begin
		out_data.token_kind = cur.kind;
		out_data.token_line = cur.line;
		out_data.token_column = cur.column;
		out_data.start_offset = cur.offset;
		out_data.token_length = cur.length;
		out_data.last = !first_of_two;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_v_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (pop) begin
			stage_v_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (done) begin
			stage_v_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			stage_q <= head;
		end
	end

	`KVL_ASSERT(a_back_sel_two, clk, arst_n, sel_q |-> (stage_v_q && stage_q.two), "second token selected without a pair")
	`KVL_ASSERT(a_back_pair_follows, clk, arst_n, (out_valid && !out_stall && !out_data.last) |=> (out_valid && out_data.last), "second token of a pair did not follow")

endmodule

### rtl/key_value_lexer_unit.sv
// Key/value lexer top level: configuration registers, front end, token queue and output stage.
//
// Input channel (in_valid, in_stall, in_data): one text byte or an end marker per request,
// taken at an edge where in_valid is high and in_stall is low. in_stall rises only while the
// four-entry token queue is full.
// Output channel (out_valid, out_stall, out_data): one token per request; out_data.last marks
// the final token caused by an input byte. A byte that closes an identifier and is itself a
// token gives two tokens on consecutive output requests.
// Path: a token enters the token queue when its byte is taken, then moves into the output
// register that drives out_valid. Throughput: one byte per cycle while in_stall is low and
// one token per cycle while out_stall is low; the single output register drains the queue, so
// inputs stall only while the queue is full, through a burst of tokens or a held out_stall.
// Configuration: cfg_we writes cfg_data into the register that cfg_index names (0 assign,
// 1 delimiter, 2 comment); write only while the lexer is idle.
// Reset: the queue empties, the symbol registers return to '=', ';' and '#', line and column
// return to 1 and the byte offset to 0. A stalled output token holds until it is taken.
module key_value_lexer_unit #(
	parameter int COUNT_BITS = kvl_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [kvl_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input kvl_pkg::kvl_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output kvl_pkg::kvl_out_t out_data
);

	kvl_pkg::kvl_cfg_wr_t cfg;
	logic push;
	logic full;
	logic pop;
	logic empty;
	kvl_pkg::kvl_entry_t push_data;
	kvl_pkg::kvl_entry_t head;

	always_comb begin
		cfg.we = cfg_we;
		cfg.index = kvl_pkg::cfg_reg_t'(cfg_index);
		cfg.data = cfg_data;
	end

	kvl_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	kvl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(head),
		.empty(empty)
	);

	kvl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
